@@ sv/bsc_pkg.sv @@
// types, constants and scale table for the barometric compensation core
package bsc_pkg;

  localparam int RawW     = 24;
  localparam int SclW     = 31;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int TempW    = 24;
  localparam int PresW    = 32;
  localparam int PqW      = 64;

  localparam logic signed [TempW-1:0] TempMax = {1'b0, {(TempW-1){1'b1}}};
  localparam logic signed [TempW-1:0] TempMin = {1'b1, {(TempW-1){1'b0}}};
  localparam logic signed [PresW-1:0] PresMax = {1'b0, {(PresW-1){1'b1}}};
  localparam logic signed [PresW-1:0] PresMin = {1'b1, {(PresW-1){1'b0}}};

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } bsc_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_out;
    logic signed [PresW-1:0] pressure_out;
  } bsc_out_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OVERSAMPLE     = 4'd0,
    REG_TEMP_COEFFS    = 4'd1,
    REG_PRES_OFFSET    = 4'd2,
    REG_PRES_LINEAR    = 4'd3,
    REG_TEMP_INFLUENCE = 4'd4,
    REG_CROSS_LINEAR   = 4'd5,
    REG_PRES_HIGHER    = 4'd6,
    REG_CROSS_QUAD     = 4'd7
  } bsc_reg_t;

  typedef struct packed {
    logic [2:0]         osr_p;
    logic [2:0]         osr_t;
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c30;
    logic signed [15:0] c21;
  } bsc_cfg_t;

  // scale k = div * 2^(19 or 13); q = floor(raw * 2^24 / k) = floor(raw * 2^sh / div)
  typedef struct packed {
    logic [31:0] recip;
    logic [7:0]  div;
    logic        wide;
  } bsc_scale_t;

  function automatic bsc_scale_t scale_lookup(input logic [2:0] idx);
    bsc_scale_t s;
    case (idx)
      3'd0: s = '{32'd536870912,  8'd1,   1'b0};
      3'd1: s = '{32'd178956970,  8'd3,   1'b0};
      3'd2: s = '{32'd76695844,   8'd7,   1'b0};
      3'd3: s = '{32'd35791394,   8'd15,  1'b0};
      3'd4: s = '{32'd1108378657, 8'd31,  1'b1};
      3'd5: s = '{32'd545392672,  8'd63,  1'b1};
      3'd6: s = '{32'd270549120,  8'd127, 1'b1};
      default: s = '{32'd134744072, 8'd255, 1'b1};
    endcase
    return s;
  endfunction

endpackage

@@ sv/bsc_cfg_regs.sv @@
// configuration register file with coefficient unpacking
module bsc_cfg_regs import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output bsc_cfg_t            cfg
);

  logic [5:0]  osr_r;
  logic [23:0] tco_r;
  logic [19:0] c00_r;
  logic [19:0] c10_r;
  logic [15:0] c01_r;
  logic [15:0] c11_r;
  logic [31:0] pho_r;
  logic [15:0] c21_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osr_r <= '0;
      tco_r <= '0;
      c00_r <= '0;
      c10_r <= '0;
      c01_r <= '0;
      c11_r <= '0;
      pho_r <= '0;
      c21_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERSAMPLE:     osr_r <= cfg_wdata[5:0];
        REG_TEMP_COEFFS:    tco_r <= cfg_wdata[23:0];
        REG_PRES_OFFSET:    c00_r <= cfg_wdata[19:0];
        REG_PRES_LINEAR:    c10_r <= cfg_wdata[19:0];
        REG_TEMP_INFLUENCE: c01_r <= cfg_wdata[15:0];
        REG_CROSS_LINEAR:   c11_r <= cfg_wdata[15:0];
        REG_PRES_HIGHER:    pho_r <= cfg_wdata[31:0];
        REG_CROSS_QUAD:     c21_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.osr_p = osr_r[2:0];
    cfg.osr_t = osr_r[5:3];
    cfg.c0    = tco_r[23:12];
    cfg.c1    = tco_r[11:0];
    cfg.c00   = c00_r;
    cfg.c10   = c10_r;
    cfg.c01   = c01_r;
    cfg.c11   = c11_r;
    cfg.c20   = pho_r[31:16];
    cfg.c30   = pho_r[15:0];
    cfg.c21   = c21_r;
  end

endmodule

@@ sv/bsc_scale.sv @@
// raw sample scaling: reciprocal multiply and one-step floor correction, three stages
module bsc_scale import bsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsc_cfg_t               cfg,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  bsc_in_t                up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic signed [SclW-1:0] ps,
  output logic signed [SclW-1:0] ts
);

  localparam int NStg  = 3;
  localparam int ProdW = RawW + 33;
  localparam int NumW  = RawW + 11;
  localparam int QdW   = SclW + 9;
  localparam int RemW  = QdW + 1;

  logic [NStg-1:0] v_r;
  logic [NStg:0]   en;

  logic signed [RawW-1:0]  raw_r  [2];
  logic signed [RawW-1:0]  raw1_r [2];
  logic signed [SclW-1:0]  q0_r   [2];
  logic signed [SclW-1:0]  q_r    [2];
  bsc_scale_t              sc     [2];
  logic signed [ProdW-1:0] prod   [2];
  logic signed [NumW-1:0]  num    [2];
  logic signed [QdW-1:0]   qd     [2];
  logic signed [RemW-1:0]  dl     [2];
  logic signed [RemW-1:0]  rem    [2];
  logic signed [RemW-1:0]  rfix   [2];
  logic signed [SclW-1:0]  qfix   [2];

  assign en[NStg] = dn_ready;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NStg-1];

  assign sc[0] = scale_lookup(cfg.osr_p);
  assign sc[1] = scale_lookup(cfg.osr_t);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = raw_r[l] * $signed({1'b0, sc[l].recip});
      num[l]  = sc[l].wide ? $signed({raw1_r[l], 11'd0})
                           : NumW'($signed({raw1_r[l], 5'd0}));
      qd[l]   = q0_r[l] * $signed({1'b0, sc[l].div});
      dl[l]   = $signed(RemW'(sc[l].div));
      rem[l]  = RemW'(num[l]) - RemW'(qd[l]);
      if (rem[l] < 0) begin
        qfix[l] = q0_r[l] - SclW'(1);
        rfix[l] = rem[l] + dl[l];
      end else if (rem[l] >= dl[l]) begin
        qfix[l] = q0_r[l] + SclW'(1);
        rfix[l] = rem[l] - dl[l];
      end else begin
        qfix[l] = q0_r[l];
        rfix[l] = rem[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      raw_r[0] <= up_data.raw_pressure;
      raw_r[1] <= up_data.raw_temperature;
    end
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        q0_r[l]   <= prod[l][SclW+23:24];
        raw1_r[l] <= raw_r[l];
      end
    end
    if (en[2]) begin
      for (int l = 0; l < 2; l++) begin
        q_r[l] <= qfix[l];
      end
    end
  end

  assign ps = q_r[0];
  assign ts = q_r[1];

  a_rem_p: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (rfix[0] >= 0 && rfix[0] < dl[0]))
    else $error("pressure quotient correction out of range");
  a_rem_t: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> (rfix[1] >= 0 && rfix[1] < dl[1]))
    else $error("temperature quotient correction out of range");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !up_ready |-> (dn_valid && !dn_ready))
    else $error("scale stage stalls with room left");

endmodule

@@ sv/bsc_poly.sv @@
// calibration polynomial pipeline, six stages, split wide products
module bsc_poly import bsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bsc_cfg_t                cfg,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [SclW-1:0]  ps,
  input  logic signed [SclW-1:0]  ts,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [TempW-1:0] tout,
  output logic signed [PqW-1:0]   pq
);

  localparam int NStg = 6;
  localparam int H1W  = 48;
  localparam int H2W  = 56;
  localparam int TqW  = 45;

  logic [NStg-1:0] v_r;
  logic [NStg:0]   en;

  logic signed [15:0] c30, c21, c01;
  logic signed [11:0] c1;
  assign c30 = cfg.c30;
  assign c21 = cfg.c21;
  assign c01 = cfg.c01;
  assign c1  = cfg.c1;

  // stage 0
  logic signed [46:0]     hm, gm, tim;
  logic signed [42:0]     tpm;
  logic signed [H1W-1:0]  h1_r, g1_r;
  logic signed [42:0]     tp_r;
  logic signed [46:0]     tinf0_r, tinf1_r, tinf2_r, tinf3_r;
  logic signed [SclW-1:0] ps0_r, ts0_r, ps1_r, ts1_r, ps2_r, ts2_r;

  // stage 1
  logic signed [23:0]     hh, gh;
  logic signed [24:0]     hl, gl;
  logic signed [54:0]     hphi, gphi;
  logic signed [55:0]     hplo, gplo;
  logic signed [54:0]     hphi_r, gphi_r;
  logic signed [55:0]     hplo_r, gplo_r;
  logic signed [TqW-1:0]  tq;
  logic signed [TempW-1:0] tsat;
  logic signed [TempW-1:0] tout1_r, tout2_r, tout3_r, tout4_r, tout5_r;

  // stage 2
  logic signed [H2W-1:0]  h2, g2, h2_r, g2_r;

  // stage 3
  logic signed [27:0]     hh2, gh2;
  logic signed [28:0]     hl2, gl2;
  logic signed [58:0]     pa, qa, pa_r, qa_r;
  logic signed [59:0]     pb, qb, pb_r, qb_r;

  // stage 4, 5
  logic signed [PqW-1:0]  h3, g3, shg_r, stc_r, pq_r;

  assign en[NStg] = dn_ready;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end
  assign up_ready = en[0];
  assign dn_valid = v_r[NStg-1];

  assign hm  = c30 * ps;
  assign gm  = c21 * ps;
  assign tim = c01 * ts;
  assign tpm = c1 * ts;

  assign hh   = h1_r[47:24];
  assign hl   = {1'b0, h1_r[23:0]};
  assign gh   = g1_r[47:24];
  assign gl   = {1'b0, g1_r[23:0]};
  assign hphi = hh * ps0_r;
  assign hplo = hl * ps0_r;
  assign gphi = gh * ps0_r;
  assign gplo = gl * ps0_r;

  assign tq = TqW'($signed({cfg.c0, 23'd0})) + TqW'(tp_r);
  always_comb begin
    if ((&tq[TqW-1:TempW+15]) || !(|tq[TqW-1:TempW+15])) begin
      tsat = tq[TempW+15:16];
    end else if (tq[TqW-1]) begin
      tsat = TempMin;
    end else begin
      tsat = TempMax;
    end
  end

  assign h2 = H2W'(hphi_r) + H2W'($signed(hplo_r[55:24])) +
              H2W'($signed({cfg.c10, 24'd0}));
  assign g2 = H2W'(gphi_r) + H2W'($signed(gplo_r[55:24]));

  assign hh2 = h2_r[55:28];
  assign hl2 = {1'b0, h2_r[27:0]};
  assign gh2 = g2_r[55:28];
  assign gl2 = {1'b0, g2_r[27:0]};
  assign pa  = hh2 * ps2_r;
  assign pb  = hl2 * ps2_r;
  assign qa  = gh2 * ts2_r;
  assign qb  = gl2 * ts2_r;

  assign h3 = PqW'($signed({pa_r, 4'd0})) + PqW'($signed(pb_r[59:24]));
  assign g3 = PqW'($signed({qa_r, 4'd0})) + PqW'($signed(qb_r[59:24]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1_r    <= H1W'(hm) + H1W'($signed({cfg.c20, 24'd0}));
      g1_r    <= H1W'(gm) + H1W'($signed({cfg.c11, 24'd0}));
      tp_r    <= tpm;
      tinf0_r <= tim;
      ps0_r   <= ps;
      ts0_r   <= ts;
    end
    if (en[1]) begin
      hphi_r  <= hphi;
      hplo_r  <= hplo;
      gphi_r  <= gphi;
      gplo_r  <= gplo;
      tout1_r <= tsat;
      tinf1_r <= tinf0_r;
      ps1_r   <= ps0_r;
      ts1_r   <= ts0_r;
    end
    if (en[2]) begin
      h2_r    <= h2;
      g2_r    <= g2;
      tout2_r <= tout1_r;
      tinf2_r <= tinf1_r;
      ps2_r   <= ps1_r;
      ts2_r   <= ts1_r;
    end
    if (en[3]) begin
      pa_r    <= pa;
      pb_r    <= pb;
      qa_r    <= qa;
      qb_r    <= qb;
      tout3_r <= tout2_r;
      tinf3_r <= tinf2_r;
    end
    if (en[4]) begin
      shg_r   <= h3 + g3;
      stc_r   <= PqW'(tinf3_r) + PqW'($signed({cfg.c00, 24'd0}));
      tout4_r <= tout3_r;
    end
    if (en[5]) begin
      pq_r    <= shg_r + stc_r;
      tout5_r <= tout4_r;
    end
  end

  assign tout = tout5_r;
  assign pq   = pq_r;

endmodule

@@ sv/baro_sensor_compensation_core.sv @@
// barometric pressure and temperature compensation core, top level
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall   | bsc_in_t (raw pressure, raw temperature)
//   out_    | output    | out_valid/out_stall | bsc_out_t (temperature, pressure)
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// one beat per cycle sustained while out_stall is low; out_valid rises once an accepted beat has passed
// (three scaling stages, six polynomial stages, one output register)
// rst_n is synchronous; it empties the pipeline and clears the configuration to zero
// stages advance into empty slots while out_stall is high; in_stall rises
// only once all ten stages hold beats and the output is stalled
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsc_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bsc_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  bsc_cfg_t               cfg;
  logic                   scl_ready, scl_valid;
  logic signed [SclW-1:0] ps, ts;
  logic                   poly_ready, poly_valid;
  logic signed [TempW-1:0] tout;
  logic signed [PqW-1:0]  pq;
  logic                   out_en;
  logic                   out_valid_r;
  bsc_out_t               out_data_r, out_nxt;

  bsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (scl_ready),
    .up_data  (in_data),
    .dn_valid (scl_valid),
    .dn_ready (poly_ready),
    .ps       (ps),
    .ts       (ts)
  );

  bsc_poly u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (scl_valid),
    .up_ready (poly_ready),
    .ps       (ps),
    .ts       (ts),
    .dn_valid (poly_valid),
    .dn_ready (out_en),
    .tout     (tout),
    .pq       (pq)
  );

  assign in_stall = ~scl_ready;
  assign out_en   = ~out_valid_r | ~out_stall;

  // pressure: floor(pq / 2^18) saturated to 32 bits
  always_comb begin
    out_nxt.temperature_out = tout;
    if ((&pq[PqW-1:PresW+17]) || !(|pq[PqW-1:PresW+17])) begin
      out_nxt.pressure_out = pq[PresW+17:18];
    end else if (pq[PqW-1]) begin
      out_nxt.pressure_out = PresMin;
    end else begin
      out_nxt.pressure_out = PresMax;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= poly_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && poly_valid) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat present right after reset");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output can drain");

endmodule
